@@ hdl/sacl_pkg.sv @@
package sacl_pkg;
   localparam int MAX_LINES_DEF = 256;
   localparam int AGE_WIDTH_DEF = 16;
   localparam int ADDR_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED = 3'd4;
   localparam logic [1:0] POL_FIFO = 2'd0;
   localparam logic [1:0] POL_LRU = 2'd1;
   localparam logic [1:0] POL_RAND = 2'd2;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   // classified lookup handed from front to back
   typedef struct packed {
      logic [7:0]  set_num;
      logic [31:0] tag;
      logic [3:0]  wl;
      logic [3:0]  ll;
      logic [1:0]  pol;
   } req_type;
endpackage

@@ hdl/sacl_ram.sv @@
module sacl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ hdl/sacl_front.sv @@
module sacl_front
   import sacl_pkg::*;
#(
   parameter int MAX_LINES = MAX_LINES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [3:0]        skip_bits,
   input  logic [3:0]        lines_log2,
   input  logic [3:0]        ways_log2,
   input  logic [1:0]        policy,
   output logic              q_valid,
   input  logic              q_take,
   output req_type           q_data
);
   localparam int LMAX = $clog2(MAX_LINES + 1) - 1;
   localparam logic [3:0] LMAX4 = 4'(LMAX);
   localparam int QD = 2;
   logic [3:0] ll, wl, sb;
   logic [ADDR_W-1:0] sh;
   req_type item;
   req_type q_ff [QD];
   logic [1:0] cnt_ff, cnt_in;
   logic rp_ff, rp_in, wp_ff, wp_in;
   logic wr, rd;

   always_comb begin
      ll = (lines_log2 > LMAX4) ? LMAX4 : lines_log2;
      wl = (ways_log2 > ll) ? ll : ways_log2;
      sb = ll - wl;
      sh = req_address >> skip_bits;
      item.set_num = 8'(sh & ((ADDR_W'(1) << sb) - ADDR_W'(1)));
      item.tag = ADDR_W'({1'b0, req_address} >> ({1'b0, skip_bits} + {1'b0, sb}));
      item.wl = wl;
      item.ll = ll;
      item.pol = policy;
   end

   assign full = (cnt_ff == 2'(QD));
   assign wr = push && !full;
   assign rd = q_take && q_valid;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = q_ff[rp_ff];
   assign cnt_in = cnt_ff + 2'(wr) - 2'(rd);
   assign rp_in = rp_ff ^ rd;
   assign wp_in = wp_ff ^ wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rp_ff <= 1'b0;
         wp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff <= rp_in;
         wp_ff <= wp_in;
      end
      if (wr) q_ff[wp_ff] <= item;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(QD))
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      (wr && !rd) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count lost a write");
   assert property (@(posedge clock) disable iff (reset)
      !q_valid |-> !rd) else $error("read of empty queue");
endmodule

@@ hdl/sacl_back.sv @@
module sacl_back
   import sacl_pkg::*;
#(
   parameter int MAX_LINES = MAX_LINES_DEF,
   parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_take,
   input  req_type     q_data,
   input  logic        seed_load,
   input  logic [15:0] seed_value,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_hit,
   output logic [7:0]  rsp_set_number,
   output logic [7:0]  rsp_way_number,
   output logic [31:0] rsp_tag_value
);
   localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int WW = LW + 1;
   localparam logic [AGE_WIDTH-1:0] AGE_TOP = '1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_AGE = 3'd3;
   localparam logic [2:0] ST_FILL = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;
   localparam logic [2:0] ST_CLEAR = 3'd6;

   logic [2:0] st_ff, st_in;
   req_type r_ff;
   logic [WW-1:0] k_ff, k_in;      // way being walked
   logic [WW-1:0] ways;
   logic [WW-1:0] way_ff, way_in;
   logic hit_ff, hit_in;
   logic [AGE_WIDTH-1:0] best_ff, best_in;
   logic [15:0] lfsr_ff, lfsr_in, lfsr_step;
   logic [MAX_LINES-1:0] valid_ff;
   logic [LW-1:0] clr_ff, clr_in;
   logic [7:0] fptr_rd, fptr_wd;
   logic fptr_we;
   logic [LW-1:0] fptr_wa;
   logic rsp_full_ff;
   logic hit_o_ff, hit_o_in;
   logic [7:0] set_o_ff, way_o_ff;
   logic [31:0] tag_o_ff;
   logic [LW-1:0] base, line_k, line_w, set_idx;
   logic lru;
   logic [31:0] tag_rd;
   logic [AGE_WIDTH-1:0] age_rd, age_wd;
   logic tag_we, age_we;
   logic [LW-1:0] age_wa, rd_line;
   logic [WW-1:0] rd_k_in;
   logic walk_done;

   assign ways = WW'(1) << r_ff.wl;
   assign base = LW'((32'(r_ff.set_num) << r_ff.wl));
   assign line_k = base + LW'(k_ff);
   assign line_w = base + LW'(way_ff);
   assign set_idx = LW'(r_ff.set_num);
   assign lru = r_ff.pol[0];
   assign lfsr_step = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);
   assign clr_in = clr_ff + LW'(1);

   // RAM read address runs one way ahead so data for way k arrives when k is current
   assign rd_line = base + LW'(rd_k_in);

   sacl_ram #(.WIDTH(32), .DEPTH(1 << LW)) u_tag (
      .clock, .wr_en(tag_we), .wr_addr(line_w), .wr_data(r_ff.tag),
      .rd_addr(rd_line), .rd_data(tag_rd));
   sacl_ram #(.WIDTH(AGE_WIDTH), .DEPTH(1 << LW)) u_age (
      .clock, .wr_en(age_we), .wr_addr(age_wa), .wr_data(age_wd),
      .rd_addr(rd_line), .rd_data(age_rd));

   // pointer of the current set is read from the take onward, used in ST_AGE
   assign fptr_we = (st_ff == ST_CLEAR) ||
                    (st_ff == ST_AGE && !hit_ff && r_ff.pol == POL_FIFO);
   assign fptr_wa = (st_ff == ST_CLEAR) ? clr_ff : set_idx;
   assign fptr_wd = (st_ff == ST_CLEAR) ? 8'd0 :
                    8'((fptr_rd + 8'd1) & 8'(ways - WW'(1)));
   sacl_ram #(.WIDTH(8), .DEPTH(1 << LW)) u_fptr (
      .clock, .wr_en(fptr_we), .wr_addr(fptr_wa), .wr_data(fptr_wd),
      .rd_addr(set_idx), .rd_data(fptr_rd));

   assign walk_done = (k_ff == ways - WW'(1));
   assign q_take = (st_ff == ST_IDLE) && q_valid;
   assign empty = !rsp_full_ff;
   assign rsp_hit = hit_o_ff;
   assign rsp_set_number = set_o_ff;
   assign rsp_way_number = way_o_ff;
   assign rsp_tag_value = tag_o_ff;

   always_comb begin
      st_in = st_ff;
      k_in = k_ff;
      rd_k_in = k_ff;
      way_in = way_ff;
      hit_in = hit_ff;
      best_in = best_ff;
      lfsr_in = lfsr_ff;
      tag_we = 1'b0;
      age_we = 1'b0;
      age_wa = line_k;
      age_wd = '0;
      hit_o_in = hit_ff;
      unique case (st_ff)
         ST_CLEAR: begin
            // zero ages and FIFO pointers, one line a cycle
            age_we = 1'b1;
            age_wa = clr_ff;
            if (&clr_ff) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) st_in = ST_READ;
         end
         ST_READ: begin
            // address for way 0 issued this cycle
            k_in = '0;
            rd_k_in = '0;
            hit_in = 1'b0;
            way_in = '0;
            best_in = '0;
            st_in = ST_CHECK;
         end
         ST_CHECK: begin
            // tag and age of way k present
            if (!hit_ff && valid_ff[line_k] && tag_rd == r_ff.tag) begin
               hit_in = 1'b1;
               way_in = k_ff;
            end
            if (k_ff == '0 || age_rd > best_ff) begin
               best_in = age_rd;
               if (!hit_ff && !(valid_ff[line_k] && tag_rd == r_ff.tag) && lru)
                  way_in = k_ff;
            end
            if (walk_done) begin
               k_in = '0;
               rd_k_in = '0;
               st_in = ST_AGE;
            end else begin
               k_in = k_ff + WW'(1);
               rd_k_in = k_ff + WW'(1);
            end
         end
         ST_AGE: begin
            if (!hit_ff && r_ff.pol == POL_FIFO)
               way_in = WW'(fptr_rd & 8'(ways - WW'(1)));
            else if (!hit_ff && r_ff.pol == POL_RAND) begin
               lfsr_in = lfsr_step;
               way_in = WW'(lfsr_step & 16'(ways - WW'(1)));
            end
            st_in = ST_FILL;
         end
         ST_FILL: begin
            // second walk: under LRU age each way, one per cycle
            if (lru) begin
               age_we = 1'b1;
               if (k_ff == way_ff) age_wd = '0;
               else age_wd = (age_rd == AGE_TOP) ? age_rd : age_rd + AGE_WIDTH'(1);
            end
            if (walk_done) begin
               tag_we = !hit_ff;
               st_in = ST_DONE;
            end else begin
               k_in = k_ff + WW'(1);
               rd_k_in = k_ff + WW'(1);
               st_in = ST_FILL;
            end
         end
         ST_DONE: begin
            if (!rsp_full_ff) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= '0;
         valid_ff <= '0;
         rsp_full_ff <= 1'b0;
         lfsr_ff <= 16'd1;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_CLEAR) clr_ff <= clr_in;
         lfsr_ff <= seed_load ? ((seed_value == '0) ? 16'd1 : seed_value) : lfsr_in;
         if (tag_we) valid_ff[line_w] <= 1'b1;
         if (st_ff == ST_DONE && !rsp_full_ff) rsp_full_ff <= 1'b1;
         else if (pop && rsp_full_ff) rsp_full_ff <= 1'b0;
      end
      if (q_take) r_ff <= q_data;
      k_ff <= k_in;
      way_ff <= way_in;
      hit_ff <= hit_in;
      best_ff <= best_in;
      if (st_ff == ST_DONE && !rsp_full_ff) begin
         hit_o_ff <= hit_o_in;
         set_o_ff <= r_ff.set_num;
         way_o_ff <= 8'(way_ff);
         tag_o_ff <= r_ff.tag;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CHECK || st_ff == ST_FILL) |-> k_ff < ways)
      else $error("way walk past set");
   assert property (@(posedge clock) disable iff (reset)
      tag_we |-> !hit_ff) else $error("fill on hit");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_full_ff && !pop) |=> rsp_full_ff) else $error("result dropped");
endmodule

@@ hdl/set_associative_cache_lookup.sv @@
// channel | ports                              | transaction when
// req     | push, full, req_address            | push && !full
// rsp     | empty, pop, rsp_hit/set/way/tag    | pop && !empty
// csr     | csr_valid, csr_ready, idx, data    | csr_valid && csr_ready
// A lookup holds the back end through its steps: take, issue the first read,
// one way a cycle to compare tags and ages, victim pick, one way a cycle to write
// ages (LRU only) and the fill (miss only), then the result hand-off. An unpopped result
// holds the back end. The front queue holds two classified requests; the result register
// decouples pop. Reset is synchronous and clears valid bits and control; a pass over
// all lines zeroes ages and FIFO pointers; lookups wait in the front queue until it ends.
module set_associative_cache_lookup
   import sacl_pkg::*;
#(
   parameter int MAX_LINES = MAX_LINES_DEF,
   parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [31:0]           req_address,
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_hit,
   output logic [7:0]            rsp_set_number,
   output logic [7:0]            rsp_way_number,
   output logic [31:0]           rsp_tag_value,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   logic [3:0] off_ff, lines_ff, ways_ff;
   logic [1:0] pol_ff;
   logic cw;
   logic q_valid, q_take;
   req_type q_data;

   assign csr_ready = 1'b1;
   assign cw = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= 4'd0;
         lines_ff <= 4'd6;
         ways_ff <= 4'd1;
         pol_ff <= POL_LRU;
      end else if (cw) begin
         case (csr_index)
            CSR_OFFSET: off_ff <= csr_data[3:0];
            CSR_LINES: lines_ff <= csr_data[3:0];
            CSR_WAYS: ways_ff <= csr_data[3:0];
            CSR_POLICY: pol_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   sacl_front #(.MAX_LINES(MAX_LINES)) u_front (
      .clock, .reset, .push, .full, .req_address,
      .skip_bits(off_ff), .lines_log2(lines_ff), .ways_log2(ways_ff),
      .policy(pol_ff), .q_valid, .q_take, .q_data);

   sacl_back #(.MAX_LINES(MAX_LINES), .AGE_WIDTH(AGE_WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_data,
      .seed_load(cw && csr_index == CSR_SEED), .seed_value(csr_data),
      .empty, .pop, .rsp_hit, .rsp_set_number, .rsp_way_number, .rsp_tag_value);
endmodule
